// ===== hdl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, character codes and register indexes for the wildcard
// glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int CHAR_W         = 8;
    localparam int LEN_W          = 6;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int BYTES_PER_WORD = CFG_DATA_W / CHAR_W;

    localparam logic [CHAR_W-1:0] CH_ANY      = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] CH_RUN      = 8'h2A;  // '*'
    localparam logic [CHAR_W-1:0] CH_SEP      = 8'h3B;  // ';'
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_0_7   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_8_15  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_16_23 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_24_31 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLD        = 3'd5;

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // passed from one cell to the next one up
    typedef struct packed {
        logic used;   // position lies inside the effective pattern
        logic alt;    // position holds a character of an alternative
        logic step;   // live position consumed a character, next one goes live
    } wgm_link_t;

    // per-cell status toward the top level
    typedef struct packed {
        logic raw;    // position live after this character, before star closure
        logic star;   // position holds '*'
        logic start;  // first position of an alternative
        logic fin;    // position right after the last character of an alternative
    } wgm_stat_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        logic [CHAR_W-1:0] r;
        r = c;
        if (en && (c inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== hdl/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: decodes its pattern character, holds its live bit
// and hands the consumed-character step to the next position.
// ----------------------------------------------------------------------------
module wgm_cell #(
    parameter int POS = 0
) (
    input  logic                        aclk,
    input  logic [wgm_pkg::CHAR_W-1:0]  pat_char,
    input  logic [wgm_pkg::LEN_W-1:0]   pat_len,
    input  logic                        fold_en,
    input  logic [wgm_pkg::CHAR_W-1:0]  txt_fold,
    input  logic                        restart,
    input  logic                        act_load,
    input  logic                        act_in,
    input  logic                        start_in,
    input  wgm_pkg::wgm_link_t          link_in,
    output wgm_pkg::wgm_link_t          link_out,
    output wgm_pkg::wgm_stat_t          stat
);
    import wgm_pkg::*;

    logic              pos_ok;
    logic              used_c;
    logic              sep_c;
    logic              star_c;
    logic              any_c;
    logic              cur;
    logic              act_next;

    logic              used_reg;
    logic              star_reg;
    logic              sep_reg;
    logic              any_reg;
    logic [CHAR_W-1:0] pat_fold_reg;
    logic              start_mark_reg;
    logic              end_mark_reg;
    logic              start_set_reg;
    logic              act_reg;

    // pattern decode, settles after a register write
    always_comb begin
        pos_ok = pat_len > LEN_W'(POS);
        used_c = link_in.used && pos_ok && (pat_char != '0);
        sep_c  = pat_char == CH_SEP;
        star_c = pat_char == CH_RUN;
        any_c  = pat_char == CH_ANY;
    end

    always_ff @(posedge aclk) begin
        used_reg       <= used_c;
        star_reg       <= used_c && star_c;
        sep_reg        <= used_c && sep_c;
        any_reg        <= used_c && any_c;
        pat_fold_reg   <= fold_char(pat_char, fold_en);
        start_mark_reg <= used_c && !sep_c && !link_in.alt;
        end_mark_reg   <= link_in.alt && (!used_c || sep_c);
        start_set_reg  <= start_in;
        act_reg        <= act_next;
    end

    always_comb begin
        cur      = restart ? start_set_reg : act_reg;
        act_next = act_load ? act_in : act_reg;

        link_out.used = used_c;
        link_out.alt  = used_c && !sep_c;
        link_out.step = cur && used_reg && !star_reg && !sep_reg &&
                        (any_reg || (pat_fold_reg == txt_fold));

        stat.raw   = (cur && star_reg) || link_in.step;
        stat.star  = star_reg;
        stat.start = start_mark_reg;
        stat.fin   = end_mark_reg;
    end

endmodule

// ===== hdl/wildcard_glob_matcher_core.sv =====
// The match flag appears on m_tdata in the cycle after the request with
// s_tlast is accepted; requests without s_tlast give no result.
// Throughput: one character per cycle while s_tready is high; the path is cell
// compare, then the 33-bit star-closure adder, then the end-mark reduction.
// Reset and a write to a known register index clear the name in progress; then
// s_tready stays low until the pattern decode and start set have settled.
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_core
// Streams name characters through a row of pattern-position cells and
// reports whether the whole name matched one alternative of the pattern.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_core #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // name characters
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] text_char
    input  logic                            s_tlast,   // last_char
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [0] matched, [7:1] zero
);
    import wgm_pkg::*;

    localparam int W = PATTERN_MAX + 1;

    logic [CHAR_W-1:0] pat_reg [PATTERN_MAX];
    logic [LEN_W-1:0]  len_reg;
    logic              fold_reg;
    logic [1:0]        settle_reg;
    logic [1:0]        settle_next;
    logic              inside_reg;
    logic              inside_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              match_reg;
    logic              end_last_reg;

    logic              cfg_we;
    logic              cfg_known;
    logic              s_accept;
    logic [CHAR_W-1:0] txt_fold;
    logic              match_c;

    wgm_link_t         link [PATTERN_MAX+1];
    wgm_stat_t         stat [PATTERN_MAX];

    logic [W-1:0]      raw_vec;
    logic [W-1:0]      star_vec;
    logic [W-1:0]      start_vec;
    logic [W-1:0]      end_vec;
    logic [W-1:0]      closed_vec;
    logic [W-1:0]      start_closed_vec;

    // a live position in front of a star run makes every position up to the
    // end of the run live: a carry that enters at a live star and ripples on
    function automatic logic [W-1:0] star_closure(input logic [W-1:0] set,
                                                  input logic [W-1:0] star);
        logic [W-1:0] gen;
        logic [W-1:0] sum;
        gen = set & star;
        sum = star + gen;
        return set | (sum ^ star ^ gen);
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_known = cfg_index <= REG_FOLD;
    assign s_tready  = (settle_reg == '0) && (!m_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign txt_fold  = fold_char(s_tdata, fold_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            fold_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LENGTH: begin
                    len_reg <= cfg_data[LEN_W-1:0];
                end
                REG_FOLD: begin
                    fold_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < PATTERN_MAX; b++) begin
            if (!aresetn) begin
                pat_reg[b] <= '0;
            end else if (cfg_we && (cfg_index == CFG_INDEX_W'(b / BYTES_PER_WORD))) begin
                pat_reg[b] <= cfg_data[(b % BYTES_PER_WORD)*CHAR_W +: CHAR_W];
            end
        end
    end

    // cell row
    assign link[0] = '{used: 1'b1, alt: 1'b0, step: 1'b0};

    for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
        wgm_cell #(
            .POS (p)
        ) u_cell (
            .aclk     (aclk),
            .pat_char (pat_reg[p]),
            .pat_len  (len_reg),
            .fold_en  (fold_reg),
            .txt_fold (txt_fold),
            .restart  (!inside_reg),
            .act_load (s_accept),
            .act_in   (closed_vec[p]),
            .start_in (start_closed_vec[p]),
            .link_in  (link[p]),
            .link_out (link[p+1]),
            .stat     (stat[p])
        );
    end

    always_ff @(posedge aclk) begin
        end_last_reg <= link[PATTERN_MAX].alt;
    end

    always_comb begin
        for (int p = 0; p < PATTERN_MAX; p++) begin
            raw_vec[p]   = stat[p].raw;
            star_vec[p]  = stat[p].star;
            start_vec[p] = stat[p].start;
            end_vec[p]   = stat[p].fin;
        end
        raw_vec[PATTERN_MAX]   = link[PATTERN_MAX].step;
        star_vec[PATTERN_MAX]  = 1'b0;
        start_vec[PATTERN_MAX] = 1'b0;
        end_vec[PATTERN_MAX]   = end_last_reg;

        closed_vec       = star_closure(raw_vec, star_vec);
        start_closed_vec = star_closure(start_vec, star_vec);
        match_c          = |(closed_vec & end_vec);
    end

    // name tracking, settle count and result register
    always_comb begin
        settle_next = settle_reg;
        if (settle_reg != '0) begin
            settle_next = settle_reg - 2'd1;
        end
        if (cfg_we && cfg_known) begin
            settle_next = SETTLE_CYCLES;
        end

        inside_next = inside_reg;
        if (s_accept) begin
            inside_next = !s_tlast;
        end
        if (cfg_we && cfg_known) begin
            inside_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept && s_tlast) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= SETTLE_CYCLES;
            inside_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            settle_reg  <= settle_next;
            inside_reg  <= inside_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            match_reg <= match_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, match_reg};

    // new result only from a request that closed a name
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_accept && s_tlast))
        else $error("result without a closing request");

    // a register write drops the name in progress
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && cfg_known) |=> !inside_reg && (settle_reg == SETTLE_CYCLES))
        else $error("register write did not restart the matcher");

    // a held result blocks further characters
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("character taken while a result is stalled");

    // a character that does not close a name leaves a name in progress
    a_inside_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tlast && !cfg_we) |=> inside_reg)
        else $error("name in progress lost");

endmodule
